// ----- rtl/abr_pkg.sv -----
// Package for the automatic backlight ramp controller.
// Holds the request action codes, register indexes and fixed-point constants.
// No dependencies.
`default_nettype none

package abr_pkg;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_ON   = 2'd1,
    ACT_OFF  = 2'd2
  } action_t;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LEVEL = 1'b0,
    CFG_MAX_LEVEL = 1'b1
  } cfg_index_t;

  localparam logic [7:0] MIN_LEVEL_RST = 8'd10;
  localparam logic [7:0] MAX_LEVEL_RST = 8'd255;
  localparam logic [7:0] FULL_LEVEL    = 8'd255;

  // Level arithmetic is done in 18-bit signed Q10.8.
  localparam int LVL_W = 18;
  localparam logic signed [LVL_W-1:0] ONE_Q      = 18'sd256;
  localparam logic signed [LVL_W-1:0] MAN_STEP_Q = 18'sd2560;

endpackage

`default_nettype wire

// ----- rtl/auto_backlight_ramp_core.sv -----
// Top level of the automatic backlight ramp controller.
// Ambient sample ring, running sum, target and Q8.8 ramp, output skid buffer.
// Depends on abr_pkg.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | in_action, in_light_sample
//  out     | output    | out_valid/out_ready | out_pwm_level
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A request is taken per cycle while in_ready is high; results are registered.
// The sample ring and the ramp are updated in a single pass per request.
// A two-entry output buffer lets requests keep flowing while one result waits;
// in_ready drops only when both entries are full.
// Reset is synchronous and clears the ring through per-entry valid bits at once.
// The configuration port is always ready.
`default_nettype none

module auto_backlight_ramp_core
  import abr_pkg::*;
#(
  parameter int SAMPLE_COUNT = 8
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  [1:0]           in_action,
  input  wire  [7:0]           in_light_sample,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [7:0]           out_pwm_level,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [CFG_IDX_W-1:0] cfg_index,
  input  wire  [7:0]           cfg_data
);

  localparam int LOG_N = $clog2(SAMPLE_COUNT);
  localparam int POS_W = (SAMPLE_COUNT > 1) ? LOG_N : 1;
  localparam int TOT_W = 8 + LOG_N;
  localparam int SHIFT = TOT_W + LOG_N;
  localparam int MUL_W = TOT_W + 2;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + SAMPLE_COUNT - 1) / SAMPLE_COUNT;
  localparam logic [MUL_W-1:0] RECIP_V = MUL_W'(RECIP);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(SAMPLE_COUNT - 1);

  logic [7:0]       min_level_r, max_level_r;
  logic [7:0]       mem [SAMPLE_COUNT];
  logic [SAMPLE_COUNT-1:0] vld_r, vld_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic [15:0]      level_r, level_nxt;
  logic [7:0]       goal_r, goal_nxt;
  logic             light_on_r, light_on_nxt;
  logic             follow_r, follow_nxt;
  logic [7:0]       rd_data_r, byp_data_r;
  logic             rd_vld_r, rd_byp_r;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_pwm_r, out_pwm_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  logic [7:0]       skid_pwm_r, skid_pwm_nxt;

  logic                   accept, store, res;
  logic [7:0]             old_sample;
  logic [TOT_W+MUL_W-1:0] prod;
  logic [7:0]             avg, inv, target, goal_eff;
  logic signed [LVL_W-1:0] goal_q, now_q, top_q, delta, delta_adj, step, sum_q, new_q, err;

  assign in_ready  = !skid_valid_r;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_pwm_level = out_pwm_r;

  assign old_sample = rd_byp_r ? byp_data_r : (rd_vld_r ? rd_data_r : 8'd0);

  always_comb begin
    prod = TOT_W'(total_r) * RECIP_V;
    avg  = prod[SHIFT +: 8];
    inv  = FULL_LEVEL - avg;
    target = (inv < min_level_r) ? min_level_r : inv;
    if (target > max_level_r) begin
      target = max_level_r;
    end
  end

  always_comb begin
    goal_eff  = follow_r ? target : goal_r;
    goal_q    = LVL_W'({2'b00, goal_eff, 8'h00});
    now_q     = LVL_W'({2'b00, level_r});
    top_q     = LVL_W'({2'b00, max_level_r, 8'h00});
    delta     = goal_q - now_q;
    delta_adj = delta + LVL_W'({3{delta[LVL_W-1]}});
    if (follow_r) begin
      step = delta_adj >>> 3;
    end else begin
      step = (delta < MAN_STEP_Q) ? delta : MAN_STEP_Q;
    end
    sum_q = now_q + step;
    new_q = now_q;
    if (delta > ONE_Q || delta < -ONE_Q) begin
      new_q = sum_q;
      if (sum_q < 0) begin
        new_q = '0;
      end
      if (sum_q > top_q) begin
        new_q = top_q;
      end
    end
    err = goal_q - new_q;
  end

  always_comb begin
    store        = 1'b0;
    pos_nxt      = pos_r;
    vld_nxt      = vld_r;
    total_nxt    = total_r;
    level_nxt    = level_r;
    goal_nxt     = goal_r;
    light_on_nxt = light_on_r;
    follow_nxt   = follow_r;
    if (accept) begin
      case (in_action)
        ACT_ON: begin
          light_on_nxt = 1'b1;
          follow_nxt   = 1'b0;
          goal_nxt     = target;
        end
        ACT_OFF: begin
          light_on_nxt = 1'b0;
          follow_nxt   = 1'b0;
          goal_nxt     = 8'd0;
        end
        ACT_TICK: begin
          if (follow_r || level_r[15:8] != goal_r) begin
            store      = 1'b1;
            goal_nxt   = goal_eff;
            pos_nxt    = (pos_r == LAST_POS) ? '0 : pos_r + 1'b1;
            vld_nxt[pos_r] = 1'b1;
            total_nxt  = total_r - TOT_W'(old_sample) + TOT_W'(in_light_sample);
            level_nxt  = new_q[15:0];
            if (err < ONE_Q && err > -ONE_Q) begin
              level_nxt  = goal_q[15:0];
              follow_nxt = light_on_r;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res = store;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_pwm_nxt    = out_pwm_r;
    skid_valid_nxt = skid_valid_r;
    skid_pwm_nxt   = skid_pwm_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_pwm_nxt    = skid_pwm_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res;
        out_pwm_nxt   = level_nxt[15:8];
      end
    end else if (res) begin
      skid_valid_nxt = 1'b1;
      skid_pwm_nxt   = level_nxt[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      mem[pos_r] <= in_light_sample;
      rd_data_r  <= mem[pos_nxt];
      byp_data_r <= in_light_sample;
    end
    out_pwm_r  <= out_pwm_nxt;
    skid_pwm_r <= skid_pwm_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_level_r  <= MIN_LEVEL_RST;
      max_level_r  <= MAX_LEVEL_RST;
      vld_r        <= '0;
      pos_r        <= '0;
      total_r      <= '0;
      level_r      <= '0;
      goal_r       <= '0;
      light_on_r   <= 1'b0;
      follow_r     <= 1'b0;
      rd_vld_r     <= 1'b0;
      rd_byp_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_LEVEL: min_level_r <= cfg_data;
          CFG_MAX_LEVEL: max_level_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (store) begin
        rd_vld_r <= vld_r[pos_nxt];
        rd_byp_r <= (pos_nxt == pos_r);
      end
      vld_r        <= vld_nxt;
      pos_r        <= pos_nxt;
      total_r      <= total_nxt;
      level_r      <= level_nxt;
      goal_r       <= goal_nxt;
      light_on_r   <= light_on_nxt;
      follow_r     <= follow_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a head entry");

  a_follow_needs_light: assert property (@(posedge clk) disable iff (!rst_n)
    follow_r |-> light_on_r)
    else $error("auto-follow active while the backlight is off");

  a_off_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == ACT_OFF) |=> (!light_on_r && !follow_r && goal_r == 8'd0))
    else $error("off request did not clear the target");

  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == ACT_TICK && !follow_r && level_r[15:8] == goal_r)
      |=> ($stable(level_r) && $stable(total_r) && $stable(pos_r)))
    else $error("idle tick changed the state");

endmodule

`default_nettype wire
